// File: hdl/mbss_pkg.sv
// Shared constants, types and helpers of the masked byte signature search.
package mbss_pkg;

    localparam int SIG_MAX     = 32;
    localparam int SLOT_W      = 5;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int OFFSET_BITS = 32;
    localparam int RES_W       = 32;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DATA = 1'b1
    } t_opcode;

    // One signature slot write.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] value;
        logic              must;
    } t_load;

    // One region byte to push through the matcher.
    typedef struct packed {
        logic              en;
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] value;
    } t_step;

    // Signature laid out by window age: entry 0 faces the newest byte.
    typedef struct packed {
        logic [SIG_MAX-1:0][BYTE_W-1:0] bytes;
        logic [SIG_MAX-1:0]             care;
    } t_aligned;

    // Result of one step.
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [RES_W-1:0] offset;
    } t_result;

    // Map a written length onto the range 1..SIG_MAX.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (32'(v) > SIG_MAX) begin
            r = LEN_W'(SIG_MAX);
        end
        return r;
    endfunction

endpackage

// File: hdl/mbss_in_if.sv
// Input channel: signature loads and region data bytes.
interface mbss_in_if;
    import mbss_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] byte_value;
    logic              must_match;
    logic              region_start;
    logic              region_end;

    modport source (
        output valid, opcode, slot, byte_value, must_match, region_start, region_end,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot, byte_value, must_match, region_start, region_end,
        output ready
    );
endinterface

// File: hdl/mbss_out_if.sv
// Result channel: one search result per region.
interface mbss_out_if;
    import mbss_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [RES_W-1:0] match_offset;

    modport source (output valid, found, match_offset, input ready);
    modport sink   (input valid, found, match_offset, output ready);
endinterface

// File: hdl/mbss_cfg_if.sv
// Configuration write channel carrying the pattern length.
interface mbss_cfg_if;
    import mbss_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hdl/mbss_sig_store.sv
// Signature slot store with an age-aligned copy for the window compare.
module mbss_sig_store
    import mbss_pkg::*;
(
    input  logic             i_clk,
    input  t_load            i_load,
    input  logic [LEN_W-1:0] i_len_next,
    output t_aligned         o_aligned
);

    localparam int ENT_W = BYTE_W + 1;

    logic [BYTE_W-1:0]          r_byte [SIG_MAX];
    logic                       r_care [SIG_MAX];
    logic [BYTE_W-1:0]          n_byte [SIG_MAX];
    logic                       n_care [SIG_MAX];
    logic [SIG_MAX*ENT_W-1:0]   rev;
    logic [SIG_MAX*ENT_W-1:0]   shifted;
    logic [LEN_W-1:0]           shamt;
    t_aligned                   r_aligned;
    t_aligned                   n_aligned;

    always_comb begin
        n_byte = r_byte;
        n_care = r_care;
        if (i_load.en) begin
            n_byte[i_load.slot] = i_load.value;
            n_care[i_load.slot] = i_load.must;
        end
    end

    // Slot j lines up with window age len-1-j: reverse the slots, then
    // drop SIG_MAX-len entries off the bottom. Entries past len get care 0.
    always_comb begin
        for (int a = 0; a < SIG_MAX; a++) begin
            rev[a*ENT_W +: ENT_W] = {n_care[SIG_MAX-1-a], n_byte[SIG_MAX-1-a]};
        end
        shamt   = LEN_W'(SIG_MAX) - i_len_next;
        shifted = rev >> (ENT_W * int'(shamt));
        for (int a = 0; a < SIG_MAX; a++) begin
            n_aligned.bytes[a] = shifted[a*ENT_W +: BYTE_W];
            n_aligned.care[a]  = shifted[a*ENT_W + BYTE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_care    <= n_care;
        r_aligned <= n_aligned;
    end

    assign o_aligned = r_aligned;

endmodule

// File: hdl/mbss_matcher.sv
// Byte window, region count and masked compare producing region results.
module mbss_matcher
    import mbss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_step            i_step,
    input  logic [LEN_W-1:0] i_len,
    input  t_aligned         i_aligned,
    output t_result          o_result
);

    logic [BYTE_W-1:0]      r_win [SIG_MAX];
    logic [OFFSET_BITS-1:0] r_count;
    logic                   r_done;
    logic [BYTE_W-1:0]      win_new [SIG_MAX];
    logic [OFFSET_BITS-1:0] cnt0;
    logic [OFFSET_BITS-1:0] cnt1;
    logic                   done0;
    logic                   all_eq;
    logic                   hit;
    logic [OFFSET_BITS-1:0] n_count;
    logic                   n_done;

    always_comb begin
        win_new[0] = i_step.value;
        for (int a = 1; a < SIG_MAX; a++) begin
            win_new[a] = r_win[a-1];
        end
    end

    always_comb begin
        cnt0  = i_step.first ? '0 : r_count;
        done0 = i_step.first ? 1'b0 : r_done;
        cnt1  = (cnt0 == COUNT_MAX) ? cnt0 : cnt0 + OFFSET_BITS'(1);
        all_eq = 1'b1;
        for (int a = 0; a < SIG_MAX; a++) begin
            if (i_aligned.care[a] && (i_aligned.bytes[a] != win_new[a])) begin
                all_eq = 1'b0;
            end
        end
        hit = !done0 && (cnt1 >= OFFSET_BITS'(i_len)) && all_eq;

        o_result.valid  = i_step.en && (hit || (i_step.last && !done0));
        o_result.found  = hit;
        o_result.offset = hit ? RES_W'(cnt1 - OFFSET_BITS'(i_len)) : '0;

        n_count = i_step.last ? '0 : cnt1;
        n_done  = i_step.last ? 1'b0 : (done0 || hit);
    end

    always_ff @(posedge i_clk) begin
        if (i_step.en) begin
            r_win <= win_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (i_step.en) begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

endmodule

// File: hdl/masked_byte_signature_search_core.sv
// Top level of the masked byte signature search: input register, store, matcher, result register.
//
// Streams byte regions and reports, once per region, the offset of the first
// position where the loaded signature matches, or not-found at the region end.
// Load transactions (opcode 0) write one signature slot: a byte and a care
// bit, where care 0 makes the slot a wildcard. Data transactions (opcode 1)
// carry one region byte each; region_start and region_end mark the bounds, and
// a byte with both is a one-byte region. A load takes effect for every data
// byte accepted after it. Throughput is one transaction per clock while the
// result register is free. A transaction passes through the input register
// into the masked window compare (SIG_MAX parallel byte equalities and an AND
// reduction), whose outcome is registered in the result register.
// While a result waits in the result register, the input side takes one more
// transaction into the input register and then holds it, whether or not it
// would produce a result, until the waiting result is taken. Slots must be
// loaded before they are used by a compare. The user must write the length
// port only while the block is idle; the block itself does not enforce it. A
// length of 0 acts as 1, and one above SIG_MAX acts as SIG_MAX.
module masked_byte_signature_search_core
    import mbss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbss_in_if.sink     i_in,
    mbss_cfg_if.sink    i_cfg,
    mbss_out_if.source  o_out
);

    // Input register
    logic              r_in_valid;
    logic              r_in_opcode;
    logic [SLOT_W-1:0] r_in_slot;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_must;
    logic              r_in_start;
    logic              r_in_end;

    // Result register
    logic             r_out_valid;
    logic             r_out_found;
    logic [RES_W-1:0] r_out_offset;

    // Effective pattern length
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;

    logic     out_free;
    logic     advance;
    t_load    load;
    t_step    step;
    t_aligned aligned;
    t_result  result;

    // Advance the held transaction only when the result register can take
    // whatever it produces.
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_opcode <= i_in.opcode;
            r_in_slot   <= i_in.slot;
            r_in_byte   <= i_in.byte_value;
            r_in_must   <= i_in.must_match;
            r_in_start  <= i_in.region_start;
            r_in_end    <= i_in.region_end;
        end
    end

    // Clamp the length once on write; the store realigns from the next value.
    assign n_len = (i_cfg.valid && i_cfg.ready) ? clamp_len(i_cfg.data) : r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else begin
            r_len <= n_len;
        end
    end

    always_comb begin
        load.en    = advance && (r_in_opcode == OP_LOAD);
        load.slot  = r_in_slot;
        load.value = r_in_byte;
        load.must  = r_in_must;

        step.en    = advance && (r_in_opcode == OP_DATA);
        step.first = r_in_start;
        step.last  = r_in_end;
        step.value = r_in_byte;
    end

    mbss_sig_store u_sig_store (
        .i_clk      (i_clk),
        .i_load     (load),
        .i_len_next (n_len),
        .o_aligned  (aligned)
    );

    mbss_matcher u_matcher (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_len     (r_len),
        .i_aligned (aligned),
        .o_result  (result)
    );

    // Hold a result until taken; load a new one whenever a step emits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_out_found  <= result.found;
            r_out_offset <= result.offset;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out_found;
    assign o_out.match_offset = r_out_offset;

endmodule

// File: dv/mbss_search_check_pkg.sv
// Result tracker for the masked byte signature search testbench.
`timescale 1ns / 100ps

package mbss_search_check_pkg;
    import mbss_pkg::*;

    typedef struct packed {
        bit             found;
        bit [RES_W-1:0] offset;
    } region_result_t;

    class region_match_tracker;
        bit [BYTE_W-1:0]      sig_bytes [SIG_MAX];
        bit                   care [SIG_MAX];
        bit [BYTE_W-1:0]      recent [SIG_MAX];
        bit [OFFSET_BITS-1:0] bytes_seen;
        bit                   match_done;
        bit [LEN_W-1:0]       length_reg;
        region_result_t       pending_results [$];
        int unsigned          mismatches;

        function new();
            length_reg = LEN_W'(1);
            bytes_seen = '0;
            match_done = 1'b0;
            mismatches = 0;
        endfunction

        function void set_length(bit [LEN_W-1:0] v);
            length_reg = v;
        endfunction

        // Zero acts as one, anything past the store depth as the full depth.
        function int unsigned active_length();
            if (length_reg == '0) begin
                return 1;
            end
            if (int'(length_reg) > SIG_MAX) begin
                return SIG_MAX;
            end
            return int'(length_reg);
        endfunction

        // Slot j faces the byte of age n-1-j; wildcard slots always pass.
        function bit window_hit(int unsigned n);
            int unsigned j;
            for (j = 0; j < n; j++) begin
                if (care[j] && sig_bytes[j] != recent[n - 1 - j]) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_transaction(t_opcode op, bit [SLOT_W-1:0] slot,
                                       bit [BYTE_W-1:0] value, bit must,
                                       bit first, bit last);
            int unsigned n;
            int          i;
            region_result_t r;
            if (op == OP_LOAD) begin
                if (int'(slot) < SIG_MAX) begin
                    sig_bytes[slot] = value;
                    care[slot]      = must;
                end
                return;
            end
            if (first) begin
                bytes_seen = '0;
                match_done = 1'b0;
            end
            for (i = SIG_MAX - 1; i > 0; i--) begin
                recent[i] = recent[i-1];
            end
            recent[0] = value;
            if (bytes_seen != COUNT_MAX) begin
                bytes_seen++;
            end
            n = active_length();
            if (!match_done && bytes_seen >= n && window_hit(n)) begin
                match_done = 1'b1;
                r.found    = 1'b1;
                r.offset   = RES_W'(bytes_seen - OFFSET_BITS'(n));
                pending_results.push_back(r);
            end
            if (last) begin
                if (!match_done) begin
                    r.found  = 1'b0;
                    r.offset = '0;
                    pending_results.push_back(r);
                end
                bytes_seen = '0;
                match_done = 1'b0;
            end
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch %0d at %0t: %s", mismatches, $time, what);
            end
        endfunction

        function void check_result(logic found, logic [RES_W-1:0] offset);
            region_result_t want;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result with none pending: found=%0b offset=%0d",
                                        found, offset));
                return;
            end
            want = pending_results.pop_front();
            if (want.found !== found) begin
                note_mismatch($sformatf("found: expected %0b, actual %0b", want.found, found));
            end
            if (want.offset !== offset) begin
                note_mismatch($sformatf("match_offset: expected %0d, actual %0d",
                                        want.offset, offset));
            end
        endfunction
    endclass

endpackage

// File: dv/testbench.sv
// Top of the masked byte signature search testbench: clock, reset, stimulus and result checking.
`timescale 1ns / 100ps

module testbench;
    import mbss_pkg::*;
    import mbss_search_check_pkg::*;

    localparam int          CLK_PERIOD  = 20;
    localparam int unsigned ITEM_TARGET = 1400;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned DRAIN_WAIT  = 4;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;

    mbss_in_if  in_ch ();
    mbss_cfg_if cfg_ch ();
    mbss_out_if res_ch ();

    masked_byte_signature_search_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    region_match_tracker tracker;
    int unsigned         src_calm;
    int unsigned         sink_calm;
    int unsigned         items_sent;
    int unsigned         cycle_count = 0;
    bit                  hold_results;
    bit                  slot_loaded [SIG_MAX];

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL masked_byte_signature_search_core");
            $finish;
        end
    end

    // Per-transaction wait, with occasional runs of back-to-back transactions.
    function automatic int unsigned draw_gap(ref int unsigned calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(15, 60);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // Entered and left at a falling edge.
    task automatic send_item(t_opcode op, bit [SLOT_W-1:0] slot, bit [BYTE_W-1:0] value,
                             bit must, bit first, bit last);
        int unsigned gap;
        gap = draw_gap(src_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.slot         <= slot;
        in_ch.byte_value   <= value;
        in_ch.must_match   <= must;
        in_ch.region_start <= first;
        in_ch.region_end   <= last;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        tracker.note_transaction(op, slot, value, must, first, last);
        if (op == OP_LOAD) begin
            slot_loaded[slot] = 1'b1;
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_load(bit [SLOT_W-1:0] slot, bit [BYTE_W-1:0] value, bit must);
        send_item(OP_LOAD, slot, value, must, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_byte(bit [BYTE_W-1:0] value, bit first, bit last);
        send_item(OP_DATA, SLOT_W'($urandom_range(0, 31)), value, 1'($urandom_range(0, 1)),
                  first, last);
    endtask

    // Hold the input until every pending result is out, then let the pipe settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_length(bit [LEN_W-1:0] v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        tracker.set_length(v);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Fill every slot the current length reads, refresh a few at random.
    task automatic load_signature();
        int unsigned act, k;
        act = tracker.active_length();
        for (k = 0; k < act; k++) begin
            if (!slot_loaded[k] || $urandom_range(0, 3) == 0) begin
                send_load(SLOT_W'(k), BYTE_W'($urandom), $urandom_range(0, 3) != 0);
            end
        end
    endtask

    // One region, optionally with the signature planted at a random position.
    task automatic send_region(int unsigned n_bytes, bit plant, bit mark_start);
        int unsigned     act, at, i, j;
        bit              narrow;
        bit [BYTE_W-1:0] b;
        act    = tracker.active_length();
        narrow = $urandom_range(0, 1);
        at     = (n_bytes > act) ? $urandom_range(0, n_bytes - act) : 0;
        for (i = 0; i < n_bytes; i++) begin
            if (narrow) begin
                b = tracker.sig_bytes[$urandom_range(0, act - 1)];
            end else begin
                b = BYTE_W'($urandom);
            end
            if (plant && i >= at && i < at + act) begin
                j = i - at;
                if (tracker.care[j]) begin
                    b = tracker.sig_bytes[j];
                end
            end
            if ($urandom_range(0, 49) == 0) begin
                send_load(SLOT_W'($urandom_range(0, 31)), BYTE_W'($urandom),
                          1'($urandom_range(0, 1)));
            end
            send_byte(b, (i == 0) && mark_start, i == n_bytes - 1);
        end
    endtask

    // Accept results with random stalls; a requested hold keeps ready low for a long stretch.
    initial begin : result_sink
        int unsigned gap;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_results) begin
                gap          = LONG_HOLD;
                hold_results = 1'b0;
            end else begin
                gap = draw_gap(sink_calm);
            end
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            tracker.check_result(res_ch.found, res_ch.match_offset);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        bit [LEN_W-1:0] lengths [8];
        int unsigned    phase, budget, act, n, k;
        lengths = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd2, 6'd33, 6'd8, 6'd31};
        in_ch.valid        = 1'b0;
        in_ch.opcode       = 1'b0;
        in_ch.slot         = '0;
        in_ch.byte_value   = '0;
        in_ch.must_match   = 1'b0;
        in_ch.region_start = 1'b0;
        in_ch.region_end   = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        items_sent         = 0;
        hold_results       = 1'b0;
        tracker            = new();
        rst_n              = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Length one after reset: exact byte, a repeat hit with no second result, one-byte regions, wildcard.
        send_load(SLOT_W'(0), 8'hFF, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h12, 1'b1, 1'b1);
        send_load(SLOT_W'(0), 8'h00, 1'b0);
        send_byte(8'h5A, 1'b1, 1'b1);

        // Three slots: wildcard, 0xAB, wildcard.
        send_load(SLOT_W'(1), 8'hAB, 1'b1);
        send_load(SLOT_W'(2), 8'h00, 1'b0);
        write_length(6'd3);
        // region shorter than the signature
        send_byte(8'hAB, 1'b1, 1'b0);
        send_byte(8'hAB, 1'b0, 1'b1);
        // hit on the closing byte of a four-byte region gives a single result
        send_byte(8'h11, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hAB, 1'b0, 1'b0);
        send_byte(8'h77, 1'b0, 1'b1);
        // hit on the closing byte
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'hAB, 1'b0, 1'b0);
        send_byte(8'h02, 1'b0, 1'b1);
        // no start mark after an end still opens a fresh region
        send_byte(8'h05, 1'b0, 1'b0);
        send_byte(8'hAB, 1'b0, 1'b0);
        send_byte(8'h06, 1'b0, 1'b1);
        // start mark in the middle restarts the count
        send_byte(8'hAB, 1'b1, 1'b0);
        send_byte(8'h05, 1'b1, 1'b0);
        send_byte(8'h09, 1'b0, 1'b0);
        send_byte(8'h0A, 1'b0, 1'b1);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < 8) begin
                write_length(lengths[phase]);
            end else begin
                write_length(LEN_W'($urandom_range(0, 63)));
            end
            load_signature();
            act = tracker.active_length();

            // Stall results for a long stretch while short regions keep coming.
            if (phase == 4) begin
                hold_results = 1'b1;
                for (k = 0; k < 40; k++) begin
                    send_region($urandom_range(1, 3), 1'b1, 1'b1);
                end
            end

            budget = items_sent + 160;
            while (items_sent < budget) begin
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 1))
                        0: send_load(SLOT_W'($urandom_range(0, 31)), BYTE_W'($urandom),
                                     1'($urandom_range(0, 1)));
                        default: send_byte(BYTE_W'($urandom), 1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1)));
                    endcase
                end else begin
                    if ($urandom_range(0, 4) == 0) begin
                        n = $urandom_range(1, act);
                    end else begin
                        n = $urandom_range(act, act + 12);
                    end
                    send_region(n, $urandom_range(0, 2) != 0, $urandom_range(0, 9) != 0);
                end
            end
            phase++;
        end

        in_ch.valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("PASS masked_byte_signature_search_core");
        end else begin
            $display("FAIL masked_byte_signature_search_core");
        end
        $finish;
    end

endmodule
